// ===== hw/rtl/ddcp_pkg.sv =====
// Shared widths, constants and the month offset table for the day number core.
`default_nettype none

package ddcp_pkg;

    localparam int DAY_W     = 5;
    localparam int MONTH_W   = 4;
    localparam int YEAR_W    = 14;
    localparam int DAYNUM_W  = 22;
    localparam int DIFF_W    = 23;
    localparam int MARKET_W  = 3;

    // Full internal day number width, wide enough for the largest 14-bit year.
    localparam int NUM_W     = 23;
    localparam int Q100_W    = 8;
    localparam int ADJ_W     = 13;
    localparam int Q5_W      = 21;

    localparam int IN_DATA_W  = 48;
    localparam int OUT_DATA_W = 80;

    localparam int NUM_STAGES = 6;

    localparam logic [MONTH_W-1:0] MONTHS_PER_YEAR = 4'd12;
    localparam logic [MONTH_W-1:0] FEB_INDEX       = 4'd1;

    // Division by 100 of a value below 2**14: multiply and shift right.
    localparam int               DIV100_MUL_W = 13;
    localparam logic [12:0]      DIV100_MUL   = 13'd5243;
    localparam int               DIV100_SHIFT = 19;
    localparam logic [YEAR_W-1:0] CENTURY     = 14'd100;
    localparam logic [YEAR_W-1:0] CENTURY_M1  = 14'd99;

    localparam logic [NUM_W-1:0] DAYS_PER_YEAR = 23'd365;

    // Division by 5 of a value below 2**23: multiply and shift right.
    localparam logic [NUM_W-1:0] DIV5_MUL   = 23'd6710887;
    localparam int               DIV5_SHIFT = 25;
    localparam logic [NUM_W-1:0] MARKET_CYCLE = 23'd5;

    typedef logic [8:0] dbm_t;

    // Days in the whole months before a month, indexed by month minus one.
    localparam dbm_t DAYS_BEFORE_MONTH [12] = '{
        9'd0,   9'd31,  9'd59,  9'd90,  9'd120, 9'd151,
        9'd181, 9'd212, 9'd243, 9'd273, 9'd304, 9'd334
    };

    function automatic dbm_t days_before_month(input logic [MONTH_W-1:0] idx);
        dbm_t res;
        res = 9'd0;
        if (idx < MONTHS_PER_YEAR) begin
            res = DAYS_BEFORE_MONTH[idx];
        end
        return res;
    endfunction

endpackage

`default_nettype wire

// ===== hw/rtl/date_day_count_and_pasaran_core.sv =====
// Top level of the date day number and market day core.
`default_nettype none

// Each input item carries two Gregorian dates; each result item carries the
// day number of both dates (0001-01-01 is day 1), the signed difference
// second minus first, and the five-day market-day code (day number mod 5,
// 0 Legi, 1 Pahing, 2 Pon, 3 Wage, 4 Kliwon) of each date. The core is a
// six-stage pipeline: stage 1 clamps month and year, stage 2 divides the
// elapsed years by 100, stage 3 forms the leap flag and the whole-year day
// count, stage 4 adds month offset and day, stage 5 divides by 5 and takes
// the difference, stage 6 takes the remainder into the output register. It
// takes one item per clock cycle while the result side is not stalled. Each
// stage holds its item when the stage after it is full and stalled, so a
// stall on the result side fills the empty stages first and then pushes
// back on s_axis_tready; nothing is dropped or repeated. A month of zero
// counts as January and above twelve as December, a year of zero counts as
// year 1 and a year above MAX_YEAR as MAX_YEAR. Days past the end of a month
// simply add on, and day zero gives the last day of the previous month.
// There is no configuration and no state beyond the pipeline.
module date_day_count_and_pasaran_core
    import ddcp_pkg::*;
#(
    parameter int MAX_YEAR = 9999
) (
    input  wire                    aclk,
    input  wire                    aresetn,
    input  wire                    s_axis_tvalid,
    output logic                   s_axis_tready,
    // first_day, first_month, first_year, second_day, second_month,
    // second_year, from bit 0 up; bits 47:46 are zero.
    input  wire [IN_DATA_W-1:0]    s_axis_tdata,
    output logic                   m_axis_tvalid,
    input  wire                    m_axis_tready,
    // first_day_number, second_day_number, day_difference,
    // first_market_day, second_market_day, from bit 0 up; bits 79:73 are zero.
    output logic [OUT_DATA_W-1:0]  m_axis_tdata
);

    // Saturation limit held at the year field width.
    localparam logic [YEAR_W-1:0] MaxYr =
        (MAX_YEAR > ((1 << YEAR_W) - 1)) ? {YEAR_W{1'b1}} : YEAR_W'(MAX_YEAR);
    // Whether every day number fits the 22-bit output field.
    localparam bit NumFits = (MAX_YEAR <= 11000);

    localparam int Lanes = 2;

    // Per-stage valid bits and advance enables.
    logic [NUM_STAGES-1:0] vld_reg;
    logic [NUM_STAGES-1:0] en;

    always_comb begin
        en[NUM_STAGES-1] = !vld_reg[NUM_STAGES-1] || m_axis_tready;
        for (int k = NUM_STAGES - 2; k >= 0; k--) begin
            en[k] = !vld_reg[k] || en[k+1];
        end
    end

    assign s_axis_tready = en[0];

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            vld_reg <= '0;
        end else begin
            if (en[0]) begin
                vld_reg[0] <= s_axis_tvalid;
            end
            for (int k = 1; k < NUM_STAGES; k++) begin
                if (en[k]) begin
                    vld_reg[k] <= vld_reg[k-1];
                end
            end
        end
    end

    // Stage 1: clamped fields.
    logic [DAY_W-1:0]    s1_day_reg   [Lanes];
    logic [MONTH_W-1:0]  s1_mon_reg   [Lanes];
    logic [YEAR_W-1:0]   s1_yr_reg    [Lanes];
    logic [YEAR_W-1:0]   s1_prev_reg  [Lanes];
    // Stage 2: quotient by 100.
    logic [DAY_W-1:0]    s2_day_reg   [Lanes];
    logic [MONTH_W-1:0]  s2_mon_reg   [Lanes];
    logic [1:0]          s2_yr_lo_reg [Lanes];
    logic [YEAR_W-1:0]   s2_prev_reg  [Lanes];
    logic [Q100_W-1:0]   s2_q100_reg  [Lanes];
    // Stage 3: leap flag and whole-year count in two parts.
    logic [DAY_W-1:0]    s3_day_reg   [Lanes];
    logic [MONTH_W-1:0]  s3_mon_reg   [Lanes];
    logic                s3_leap_reg  [Lanes];
    logic [NUM_W-1:0]    s3_base_reg  [Lanes];
    logic [ADJ_W-1:0]    s3_adj_reg   [Lanes];
    // Stage 4: full day number.
    logic [NUM_W-1:0]    s4_num_reg   [Lanes];
    // Stage 5: day number and quotient by 5.
    logic [NUM_W-1:0]    s5_num_reg   [Lanes];
    logic [Q5_W-1:0]     s5_q5_reg    [Lanes];
    logic [DIFF_W-1:0]   s5_diff_reg;
    // Stage 6: output fields.
    logic [DAYNUM_W-1:0] s6_num_reg   [Lanes];
    logic [MARKET_W-1:0] s6_mkt_reg   [Lanes];
    logic [DIFF_W-1:0]   s6_diff_reg;

    for (genvar g = 0; g < Lanes; g++) begin : g_lane
        localparam int Base = g * (DAY_W + MONTH_W + YEAR_W);

        logic [DAY_W-1:0]        in_day;
        logic [MONTH_W-1:0]      in_mon;
        logic [YEAR_W-1:0]       in_yr;
        logic [MONTH_W-1:0]      mon_next;
        logic [YEAR_W-1:0]       yr_next;
        logic [YEAR_W+DIV100_MUL_W-1:0] prod100;
        logic [YEAR_W-1:0]       r100;
        logic                    leap_next;
        logic [ADJ_W-1:0]        adj_next;
        logic [NUM_W-1:0]        num_next;
        logic [2*NUM_W-1:0]      prod5;
        logic [NUM_W-1:0]        rem5;

        assign in_day = s_axis_tdata[Base +: DAY_W];
        assign in_mon = s_axis_tdata[Base + DAY_W +: MONTH_W];
        assign in_yr  = s_axis_tdata[Base + DAY_W + MONTH_W +: YEAR_W];

        always_comb begin
            if (in_mon == '0) begin
                mon_next = '0;
            end else if (in_mon > MONTHS_PER_YEAR) begin
                mon_next = MONTHS_PER_YEAR - 4'd1;
            end else begin
                mon_next = in_mon - 4'd1;
            end
            if (in_yr > MaxYr) begin
                yr_next = MaxYr;
            end else if (in_yr == '0) begin
                yr_next = 14'd1;
            end else begin
                yr_next = in_yr;
            end
        end

        assign prod100 = (YEAR_W + DIV100_MUL_W)'(s1_prev_reg[g])
                       * (YEAR_W + DIV100_MUL_W)'(DIV100_MUL);

        // A year is a century year exactly when the elapsed years end in 99,
        // and a multiple of 400 when, in addition, the century count is 3 mod 4.
        assign r100 = s2_prev_reg[g] - YEAR_W'(s2_q100_reg[g]) * CENTURY;
        assign leap_next = (s2_yr_lo_reg[g] == 2'd0)
                        && !((r100 == CENTURY_M1) && (s2_q100_reg[g][1:0] != 2'd3));
        assign adj_next = ADJ_W'(s2_prev_reg[g] >> 2) - ADJ_W'(s2_q100_reg[g])
                        + ADJ_W'(s2_q100_reg[g] >> 2);

        assign num_next = s3_base_reg[g] + NUM_W'(s3_adj_reg[g])
                        + NUM_W'(days_before_month(s3_mon_reg[g]))
                        + NUM_W'(s3_leap_reg[g] && (s3_mon_reg[g] > FEB_INDEX))
                        + NUM_W'(s3_day_reg[g]);

        assign prod5 = (2 * NUM_W)'(s4_num_reg[g]) * (2 * NUM_W)'(DIV5_MUL);
        assign rem5  = s5_num_reg[g] - NUM_W'(s5_q5_reg[g]) * MARKET_CYCLE;

        always_ff @(posedge aclk) begin
            if (en[0]) begin
                s1_day_reg[g]  <= in_day;
                s1_mon_reg[g]  <= mon_next;
                s1_yr_reg[g]   <= yr_next;
                s1_prev_reg[g] <= yr_next - 14'd1;
            end
            if (en[1]) begin
                s2_day_reg[g]   <= s1_day_reg[g];
                s2_mon_reg[g]   <= s1_mon_reg[g];
                s2_yr_lo_reg[g] <= s1_yr_reg[g][1:0];
                s2_prev_reg[g]  <= s1_prev_reg[g];
                s2_q100_reg[g]  <= prod100[DIV100_SHIFT +: Q100_W];
            end
            if (en[2]) begin
                s3_day_reg[g]  <= s2_day_reg[g];
                s3_mon_reg[g]  <= s2_mon_reg[g];
                s3_leap_reg[g] <= leap_next;
                s3_base_reg[g] <= NUM_W'(s2_prev_reg[g]) * DAYS_PER_YEAR;
                s3_adj_reg[g]  <= adj_next;
            end
            if (en[3]) begin
                s4_num_reg[g] <= num_next;
            end
            if (en[4]) begin
                s5_num_reg[g] <= s4_num_reg[g];
                s5_q5_reg[g]  <= prod5[DIV5_SHIFT +: Q5_W];
            end
            if (en[5]) begin
                s6_num_reg[g] <= s5_num_reg[g][DAYNUM_W-1:0];
                s6_mkt_reg[g] <= rem5[MARKET_W-1:0];
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (en[4]) begin
            s5_diff_reg <= s4_num_reg[1] - s4_num_reg[0];
        end
        if (en[5]) begin
            s6_diff_reg <= s5_diff_reg;
        end
    end

    assign m_axis_tvalid = vld_reg[NUM_STAGES-1];
    assign m_axis_tdata  = {7'd0, s6_mkt_reg[1], s6_mkt_reg[0], s6_diff_reg,
                            s6_num_reg[1], s6_num_reg[0]};

    // The market-day code is a remainder by five.
    a_market_range: assert property (@(posedge aclk) disable iff (!aresetn)
        m_axis_tvalid |-> (s6_mkt_reg[0] <= 3'd4) && (s6_mkt_reg[1] <= 3'd4))
        else $error("market day code out of range");

    // The difference agrees with the two day numbers when they fit their field.
    a_diff_match: assert property (@(posedge aclk) disable iff (!aresetn)
        m_axis_tvalid |->
            (!NumFits || (s6_diff_reg == (DIFF_W'(s6_num_reg[1]) - DIFF_W'(s6_num_reg[0])))))
        else $error("day difference does not match day numbers");

    // Back pressure reaches the input only when the whole pipeline is full.
    a_backpressure: assert property (@(posedge aclk) disable iff (!aresetn)
        !s_axis_tready |-> (&vld_reg) && !m_axis_tready)
        else $error("input stalled with room in the pipeline");

endmodule

`default_nettype wire

// ===== bench/tb_date_day_count_and_pasaran_core.sv =====
// Self-checking testbench for the date day number and market day core.
`default_nettype none

// The bench feeds pairs of dates into the core on the input stream and checks
// every result item against an independent day number calculator kept here.
// A short directed set covers range extremes, the leap year rules and the
// clamping of odd months, years and days. A long random set follows, mostly
// real calendar dates with some raw bit patterns mixed in. Both stream sides
// idle at random. The result side also holds off for long stretches so that
// the pipeline fills and pushes back on the input. The input side pauses
// twice until the core has drained completely.
module tb_date_day_count_and_pasaran_core;
    import ddcp_pkg::*;

    localparam int unsigned YEAR_CAP     = 9999;
    localparam int          RANDOM_ITEMS = 1900;
    localparam int          IDLE_LIMIT   = 2000;
    localparam int          LONG_HOLD    = 60;
    localparam int          TAIL_CYCLES  = 12;

    // One input item: two dates and a flag that makes the driver wait for an
    // empty pipeline before offering it.
    typedef struct {
        logic [DAY_W-1:0]   first_day;
        logic [MONTH_W-1:0] first_month;
        logic [YEAR_W-1:0]  first_year;
        logic [DAY_W-1:0]   second_day;
        logic [MONTH_W-1:0] second_month;
        logic [YEAR_W-1:0]  second_year;
        bit                 drain_first;
    } date_pair_t;

    // One result item as the core should produce it.
    typedef struct {
        logic [DAYNUM_W-1:0] first_num;
        logic [DAYNUM_W-1:0] second_num;
        logic [DIFF_W-1:0]   delta;
        logic [MARKET_W-1:0] first_market;
        logic [MARKET_W-1:0] second_market;
    } day_result_t;

    logic                  aclk = 1'b0;
    logic                  aresetn = 1'b0;
    logic                  s_axis_tvalid = 1'b0;
    wire                   s_axis_tready;
    // first_day, first_month, first_year, second_day, second_month,
    // second_year, from bit 0 up; bits 47:46 are zero.
    logic [IN_DATA_W-1:0]  s_axis_tdata = '0;
    wire                   m_axis_tvalid;
    logic                  m_axis_tready = 1'b0;
    // first_day_number, second_day_number, day_difference,
    // first_market_day, second_market_day, from bit 0 up.
    wire  [OUT_DATA_W-1:0] m_axis_tdata;

    date_pair_t  date_queue [$];
    day_result_t due_results [$];

    int  fail_count = 0;
    int  results_seen = 0;
    int  idle_cycles = 0;
    bit  in_fire = 1'b0;

    // Wait counters for each side; a nonzero quiet count turns random idling
    // off for a stretch of items.
    int  send_gap = 0;
    int  send_quiet = 0;
    int  recv_gap = 0;
    int  recv_quiet = 0;
    int  recv_hold = 0;

    date_day_count_and_pasaran_core DUT (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata)
    );

    always begin
        #5 aclk = 1'b1;
        #5 aclk = 1'b0;
    end

    // Days in the whole months of a common year before the given month.
    function automatic int unsigned days_ahead_of_month(input int unsigned mon);
        int unsigned days;
        case (mon)
            1:       days = 0;
            2:       days = 31;
            3:       days = 59;
            4:       days = 90;
            5:       days = 120;
            6:       days = 151;
            7:       days = 181;
            8:       days = 212;
            9:       days = 243;
            10:      days = 273;
            11:      days = 304;
            default: days = 334;
        endcase
        return days;
    endfunction

    function automatic bit is_leap(input int unsigned yr);
        return ((yr % 4) == 0 && (yr % 100) != 0) || (yr % 400) == 0;
    endfunction

    // Day number counted from 0001-01-01 as day 1. Months outside 1..12 and
    // years outside 1..YEAR_CAP are pulled to the nearest legal value; the
    // day is added as it comes, so day zero and days past the month's end
    // land on neighboring dates.
    function automatic int unsigned gregorian_ordinal(input logic [DAY_W-1:0] d,
                                                      input logic [MONTH_W-1:0] m,
                                                      input logic [YEAR_W-1:0] y);
        int unsigned mon;
        int unsigned yr;
        int unsigned past;
        int unsigned n;
        mon = 32'(m);
        yr = 32'(y);
        if (mon < 1) mon = 1;
        if (mon > 12) mon = 12;
        if (yr > YEAR_CAP) yr = YEAR_CAP;
        if (yr < 1) yr = 1;
        past = yr - 1;
        n = 365 * past + past / 4 - past / 100 + past / 400;
        n += days_ahead_of_month(mon);
        if (mon > 2 && is_leap(yr)) n += 1;
        return n + 32'(d);
    endfunction

    function automatic day_result_t predict_days(input logic [IN_DATA_W-1:0] data);
        day_result_t r;
        int unsigned a;
        int unsigned b;
        a = gregorian_ordinal(data[4:0], data[8:5], data[22:9]);
        b = gregorian_ordinal(data[27:23], data[31:28], data[45:32]);
        r.first_num     = a[DAYNUM_W-1:0];
        r.second_num    = b[DAYNUM_W-1:0];
        r.delta         = DIFF_W'(b - a);
        r.first_market  = MARKET_W'(a % 5);
        r.second_market = MARKET_W'(b % 5);
        return r;
    endfunction

    function automatic int unsigned month_length(input int unsigned mon,
                                                 input int unsigned yr);
        if (mon == 2) return is_leap(yr) ? 29 : 28;
        if (mon == 4 || mon == 6 || mon == 9 || mon == 11) return 30;
        return 31;
    endfunction

    task automatic add_pair(input int fd, input int fm, input int fy,
                            input int sd, input int sm, input int sy,
                            input bit drain);
        date_pair_t p;
        p.first_day    = fd[DAY_W-1:0];
        p.first_month  = fm[MONTH_W-1:0];
        p.first_year   = fy[YEAR_W-1:0];
        p.second_day   = sd[DAY_W-1:0];
        p.second_month = sm[MONTH_W-1:0];
        p.second_year  = sy[YEAR_W-1:0];
        p.drain_first  = drain;
        date_queue.push_back(p);
    endtask

    task automatic report_field(input string name, input logic [31:0] want,
                                input logic [31:0] got);
        if (want !== got) begin
            $display("%0t: %s mismatch, expected %0d (0x%0h), actual %0d (0x%0h)",
                     $time, name, want, want, got, got);
            fail_count++;
        end
    endtask

    // Sampling side: record handshakes, predict accepted items, check results
    // against the oldest prediction and keep the watchdog.
    always @(posedge aclk) begin : sample_edge
        day_result_t want;
        bit          took_in;
        bit          took_out;
        took_in  = aresetn && s_axis_tvalid && s_axis_tready;
        took_out = aresetn && m_axis_tvalid && m_axis_tready;
        in_fire  <= took_in;

        if (took_in) begin
            due_results.push_back(predict_days(s_axis_tdata));
        end

        if (took_out) begin
            results_seen++;
            if (due_results.size() == 0) begin
                $display("%0t: result with nothing expected, actual 0x%0h",
                         $time, m_axis_tdata);
                fail_count++;
            end else begin
                want = due_results.pop_front();
                report_field("first_day_number", 32'(want.first_num),
                             32'(m_axis_tdata[21:0]));
                report_field("second_day_number", 32'(want.second_num),
                             32'(m_axis_tdata[43:22]));
                report_field("day_difference", 32'(want.delta),
                             32'(m_axis_tdata[66:44]));
                report_field("first_market_day", 32'(want.first_market),
                             32'(m_axis_tdata[69:67]));
                report_field("second_market_day", 32'(want.second_market),
                             32'(m_axis_tdata[72:70]));
            end
            // Draw the wait before the next result; long holds at two points
            // let the pipeline fill and stall the input side.
            if (recv_quiet > 0) begin
                recv_quiet--;
                recv_gap = 0;
            end else begin
                recv_gap = $urandom_range(0, 4);
                if ($urandom_range(0, 31) == 0) recv_quiet = $urandom_range(10, 40);
            end
            if (results_seen == 300 || results_seen == 1300) recv_hold = LONG_HOLD;
        end

        if (took_in || took_out) begin
            idle_cycles = 0;
        end else begin
            idle_cycles++;
            if (idle_cycles >= IDLE_LIMIT) begin
                $display("[FAIL] regression broken");
                $finish;
            end
        end
    end

    // Input driver: changes inputs at the falling edge once the previous item
    // has been taken. An item marked to drain waits for an empty pipeline.
    always @(negedge aclk) begin : drive_input
        date_pair_t p;
        if (aresetn && (!s_axis_tvalid || in_fire)) begin
            if (send_gap > 0) begin
                send_gap--;
                s_axis_tvalid <= 1'b0;
            end else if (date_queue.size() != 0 &&
                         !(date_queue[0].drain_first && due_results.size() != 0)) begin
                p = date_queue.pop_front();
                s_axis_tdata <= {2'b00, p.second_year, p.second_month, p.second_day,
                                 p.first_year, p.first_month, p.first_day};
                s_axis_tvalid <= 1'b1;
                if (send_quiet > 0) begin
                    send_quiet--;
                    send_gap = 0;
                end else begin
                    send_gap = $urandom_range(0, 4);
                    if ($urandom_range(0, 31) == 0) send_quiet = $urandom_range(10, 40);
                end
            end else begin
                s_axis_tvalid <= 1'b0;
            end
        end
    end

    // Result side ready: a long hold wins over the per-item wait.
    always @(negedge aclk) begin
        if (aresetn) begin
            if (recv_hold > 0) begin
                recv_hold--;
                m_axis_tready <= 1'b0;
            end else if (recv_gap > 0) begin
                recv_gap--;
                m_axis_tready <= 1'b0;
            end else begin
                m_axis_tready <= 1'b1;
            end
        end
    end

    initial begin : stimulus
        int fd, fm, fy, sd, sm, sy;
        int k;

        // Smallest and largest legal dates, both orders of the difference.
        add_pair(1, 1, 1, 1, 1, 1, 0);
        add_pair(31, 12, 9999, 1, 1, 1, 0);
        add_pair(1, 1, 1, 31, 12, 9999, 0);
        // Leap rules: divisible by 400, by 100 only, by 4 only.
        add_pair(29, 2, 2000, 29, 2, 1900, 0);
        add_pair(28, 2, 1600, 1, 3, 1600, 0);
        add_pair(1, 3, 2004, 1, 3, 2100, 0);
        add_pair(31, 12, 4, 1, 1, 5, 0);
        add_pair(1, 1, 400, 1, 1, 401, 0);
        add_pair(31, 12, 100, 1, 1, 101, 0);
        // Month zero counts as January, months above twelve as December.
        add_pair(15, 0, 2020, 15, 13, 2020, 0);
        add_pair(31, 15, 2021, 1, 14, 2021, 0);
        // Year zero counts as year 1, years past the cap saturate.
        add_pair(1, 1, 0, 1, 1, 10000, 0);
        add_pair(31, 15, 16383, 0, 0, 0, 0);
        add_pair(1, 1, 9999, 31, 12, 9998, 0);
        // Day zero is the last day of the previous month; 0001-01-00 is day 0.
        add_pair(0, 1, 1, 0, 3, 2000, 0);
        add_pair(0, 3, 1900, 0, 1, 2024, 0);
        // Days past the month's end roll into the next month.
        add_pair(31, 2, 2023, 31, 4, 2023, 0);
        add_pair(30, 2, 2024, 31, 11, 1999, 0);
        add_pair(17, 8, 1945, 1, 1, 2024, 0);

        // Random part: mostly real dates, some raw bit patterns.
        for (k = 0; k < RANDOM_ITEMS; k++) begin
            if ($urandom_range(0, 99) < 85) begin
                fy = $urandom_range(1, YEAR_CAP);
                fm = $urandom_range(1, 12);
                fd = $urandom_range(1, month_length(fm, fy));
                sy = ($urandom_range(0, 3) == 0) ? fy : $urandom_range(1, YEAR_CAP);
                sm = $urandom_range(1, 12);
                sd = $urandom_range(1, month_length(sm, sy));
            end else begin
                fd = $urandom_range(0, 31);
                fm = $urandom_range(0, 15);
                fy = $urandom_range(0, 16383);
                sd = $urandom_range(0, 31);
                sm = $urandom_range(0, 15);
                sy = $urandom_range(0, 16383);
            end
            // Two items wait for the pipeline to empty before they go in.
            add_pair(fd, fm, fy, sd, sm, sy, (k == 5) || (k == 1000));
        end

        repeat (9) @(negedge aclk);
        aresetn <= 1'b1;

        while (date_queue.size() != 0 || s_axis_tvalid) @(negedge aclk);
        while (due_results.size() != 0) @(negedge aclk);
        repeat (TAIL_CYCLES) @(negedge aclk);

        if (fail_count == 0) begin
            $display("[ OK ] regression clean");
        end else begin
            $display("[FAIL] regression broken");
        end
        $finish;
    end

endmodule

`default_nettype wire

// ===== files.f =====
hw/rtl/ddcp_pkg.sv
hw/rtl/date_day_count_and_pasaran_core.sv
bench/tb_date_day_count_and_pasaran_core.sv
